/* design/srf_pkg.sv */
// shared types and constants for the spectral rolloff frame block
package srf_pkg;

  localparam int unsigned MAX_BINS  = 2048;
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned BIN_W     = $clog2(MAX_BINS);
  localparam int unsigned CNT_W     = BIN_W + 1;
  localparam int unsigned TOTAL_W   = MAG_W + BIN_W;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned STEP_W    = 32;
  localparam int unsigned GOAL_W    = FRAC_W + TOTAL_W;
  localparam int unsigned PROD_W    = BIN_W + STEP_W;
  localparam int unsigned FREQ_W    = 63;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;

  localparam logic [FRAC_W-1:0] ROLL_FRACTION_RST = 16'd55705;
  localparam logic [STEP_W-1:0] BIN_STEP_HZ_RST   = 32'd1411200;

  localparam logic [CFG_IDX_W-1:0] REG_ROLL_FRACTION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP_HZ   = 1'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_GOAL,
    ST_SCAN,
    ST_FREQ,
    ST_PUSH
  } srf_state_e;

  typedef struct packed {
    logic accept;
    logic goal_en;
    logic scan_en;
    logic freq_en;
    logic push;
  } srf_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } srf_sts_t;

endpackage

/* design/srf_if.sv */
// valid/ready channel interfaces for bins in and rolloff results out
interface srf_in_if import srf_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic             last_bin;

  modport source (output valid, output magnitude, output last_bin, input ready);
  modport sink   (input valid, input magnitude, input last_bin, output ready);
endinterface

interface srf_out_if import srf_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [BIN_W-1:0]  rolloff_bin;
  logic [FREQ_W-1:0] rolloff_freq;

  modport source (output valid, output rolloff_bin, output rolloff_freq, input ready);
  modport sink   (input valid, input rolloff_bin, input rolloff_freq, output ready);
endinterface

/* design/srf_ctrl.sv */
// controller state machine sequencing frame load, scan and result transfer
module srf_ctrl import srf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  srf_sts_t sts_i,
  output srf_cmd_t cmd_o
);

  srf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_LOAD: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_GOAL;
        end
      end
      ST_GOAL: begin
        cmd_o.goal_en = 1'b1;
        state_d       = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.hit) begin
          state_d = ST_FREQ;
        end
      end
      ST_FREQ: begin
        cmd_o.freq_en = 1'b1;
        state_d       = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

/* design/srf_datapath.sv */
// bin memory, energy sums, threshold scan, frequency multiply and result register
module srf_datapath import srf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [MAG_W-1:0]     magnitude_i,
  input  srf_cmd_t             cmd_i,
  output srf_sts_t             sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [BIN_W-1:0]     rolloff_bin_o,
  output logic [FREQ_W-1:0]    rolloff_freq_o
);

  logic [MAG_W-1:0]   mem [MAX_BINS];

  logic [FRAC_W-1:0]  roll_fraction_q;
  logic [STEP_W-1:0]  bin_step_hz_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [GOAL_W-1:0]  goal_q;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic               rd_vld_q, rd_vld_d;
  logic [BIN_W-1:0]   rd_idx_q;
  logic [MAG_W-1:0]   rd_data_q;
  logic [TOTAL_W-1:0] run_q, run_d;
  logic [BIN_W-1:0]   k_q;
  logic [PROD_W-1:0]  prod_q;
  logic               out_valid_q;
  logic [BIN_W-1:0]   out_bin_q;
  logic [FREQ_W-1:0]  out_freq_q;

  logic               store_en;
  logic               issue_en;
  logic               is_last;
  logic               reach;
  logic [CNT_W-1:0]   last_idx;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_fraction_q <= ROLL_FRACTION_RST;
      bin_step_hz_q   <= BIN_STEP_HZ_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROLL_FRACTION: roll_fraction_q <= cfg_data_i[FRAC_W-1:0];
        REG_BIN_STEP_HZ:   bin_step_hz_q   <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // frame load
  assign store_en = cmd_i.accept && !count_q[CNT_W-1];

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    if (cmd_i.freq_en) begin
      count_d = '0;
      total_d = '0;
    end else if (store_en) begin
      count_d = count_q + CNT_W'(1);
      total_d = total_q + TOTAL_W'(magnitude_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      mem[count_q[BIN_W-1:0]] <= magnitude_i;
    end
  end

  // scan
  assign issue_en = cmd_i.scan_en && (issue_q < count_q);
  assign rd_vld_d = issue_en;
  assign issue_d  = cmd_i.goal_en ? '0 : (issue_en ? issue_q + CNT_W'(1) : issue_q);

  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      rd_data_q <= mem[issue_q[BIN_W-1:0]];
      rd_idx_q  <= issue_q[BIN_W-1:0];
    end
  end

  assign last_idx = count_q - CNT_W'(1);
  assign run_d    = run_q + TOTAL_W'(rd_data_q);
  assign reach    = {run_d, {FRAC_W{1'b0}}} >= goal_q;
  assign is_last  = {1'b0, rd_idx_q} == last_idx;

  assign sts_o.hit      = cmd_i.scan_en && rd_vld_q && (reach || is_last);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      total_q  <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      total_q  <= total_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.goal_en) begin
      goal_q <= GOAL_W'(roll_fraction_q * total_q);
      run_q  <= '0;
    end else if (cmd_i.scan_en && rd_vld_q) begin
      run_q <= run_d;
      k_q   <= rd_idx_q;
    end
    if (cmd_i.freq_en) begin
      prod_q <= PROD_W'(k_q * bin_step_hz_q);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_bin_q  <= k_q;
      out_freq_q <= FREQ_W'(prod_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rolloff_bin_o  = out_bin_q;
  assign rolloff_freq_o = out_freq_q;

endmodule

/* design/spectral_rolloff_frame.sv */
// spectral rolloff frame top level
// Bins are taken one per cycle into an internal memory while the frame total
// is summed. After the transfer flagged last_bin the block takes no bins until
// the result register is loaded: the threshold is formed first, the scan then
// reads the stored bins one per cycle through the single memory read port and
// stops at the rolloff bin k, k is multiplied by the bin step, and the result
// register is loaded once the previous result is taken. A waiting result does
// not block the next frame's load. Configuration writes are meant for idle
// periods only.
module spectral_rolloff_frame import srf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  srf_in_if.sink               in_i,
  srf_out_if.source            out_o
);

  srf_cmd_t cmd;
  srf_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  srf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_bin),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srf_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .magnitude_i    (in_i.magnitude),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .rolloff_bin_o  (out_o.rolloff_bin),
    .rolloff_freq_o (out_o.rolloff_freq)
  );

endmodule
